// ===== rtl/core/cascaded_recursive_bandpass_unit_macros.svh =====
// Assertion macros used by the bandpass unit controller
`ifndef CASCADED_RECURSIVE_BANDPASS_UNIT_MACROS_SVH
`define CASCADED_RECURSIVE_BANDPASS_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/crb_pkg.sv =====
// Package of the bandpass unit: widths, register indexes, commands and helpers
package crb_pkg;

  localparam int ACC_W           = 40;
  localparam int COEF_W          = 18;
  localparam int COEF_SHIFT      = 17;
  localparam int NS_W            = 4;
  localparam int CFG_W           = 18;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_STAGES_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(131072);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_HP       = 2'd0,
    CFG_C_LP       = 2'd1,
    CFG_HP_ONLY    = 2'd2,
    CFG_NUM_STAGES = 2'd3
  } crb_cfg_idx_e;

  typedef struct packed {
    logic load;  // word accepted: seed the first section
    logic pre;   // form the section difference
    logic mul;   // coefficient product
    logic wb;    // scale, saturate and write the section back
    logic lp;    // lowpass cascade when set, highpass otherwise
    logic cap;   // load the output register
  } crb_cmd_t;

  // two-bit sign extension of an accumulator value
  function automatic logic signed [ACC_W+1:0] crb_ext(input logic signed [ACC_W-1:0] a);
    crb_ext = {{2{a[ACC_W-1]}}, a};
  endfunction

  // saturate a value with two guard bits to the accumulator range
  function automatic logic signed [ACC_W-1:0] crb_sat(input logic signed [ACC_W+1:0] v);
    logic [2:0] top;
    top = v[ACC_W+1:ACC_W-1];
    if ((&top) || !(|top)) begin
      crb_sat = v[ACC_W-1:0];
    end else if (v[ACC_W+1]) begin
      crb_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      crb_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/core/crb_sample_if.sv =====
// Input stream interface of the bandpass unit: one sample per word
interface crb_sample_if #(
  parameter int SAMPLE_BITS = crb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/crb_filtered_if.sv =====
// Output stream interface of the bandpass unit: one filtered sample per word
interface crb_filtered_if #(
  parameter int SAMPLE_BITS = crb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// ===== rtl/core/cascaded_recursive_bandpass_unit.sv =====
// Top level of the cascaded recursive bandpass unit
//
// Input channel in_i carries one signed Q16.8 sample per word; output channel
// out_o returns one filtered, saturated sample per word, in order. Both use
// valid/ready: a word moves on a clock edge with both high.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i: 0 c_hp, 1 c_lp,
// 2 highpass_only, 3 num_stages. Write it only while no word is in flight.
// Each section runs as difference, product and write-back on one shared
// 19x40 multiplier, the highpass cascade first and then, in bandpass mode,
// the lowpass cascade. The unit is ready for the next word in the cycle
// after the result is registered.
// The result sits in an output register: a new word is accepted while it
// waits, but the next result is held back until the receiver takes it.
// Reset clears all section state and the previous sample and loads the
// default registers (unity coefficients, bandpass, one section).
module cascaded_recursive_bandpass_unit import crb_pkg::*; #(
  parameter int MAX_STAGES  = MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crb_sample_if.sink           in_i,
  crb_filtered_if.source       out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  logic [COEF_W-1:0] c_hp_q, c_lp_q;
  logic              hp_only_q;
  logic [NS_W-1:0]   num_stages_q;

  crb_cmd_t      cmd;
  logic [SW-1:0] idx;
  logic          in_ready, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_hp_q       <= COEF_ONE;
      c_lp_q       <= COEF_ONE;
      hp_only_q    <= 1'b0;
      num_stages_q <= NS_W'(1);
    end else if (cfg_we_i) begin
      unique case (crb_cfg_idx_e'(cfg_idx_i))
        CFG_C_HP:       c_hp_q       <= cfg_data_i[COEF_W-1:0];
        CFG_C_LP:       c_lp_q       <= cfg_data_i[COEF_W-1:0];
        CFG_HP_ONLY:    hp_only_q    <= cfg_data_i[0];
        CFG_NUM_STAGES: num_stages_q <= cfg_data_i[NS_W-1:0];
        default: ;
      endcase
    end
  end

  crb_ctrl #(
    .MAX_STAGES (MAX_STAGES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .hp_only_i    (hp_only_q),
    .num_stages_i (num_stages_q),
    .cmd_o        (cmd),
    .idx_o        (idx)
  );

  crb_datapath #(
    .MAX_STAGES  (MAX_STAGES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .sample_i   (in_i.sample),
    .c_hp_i     (c_hp_q),
    .c_lp_i     (c_lp_q),
    .filtered_o (out_o.filtered)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

// ===== rtl/core/crb_datapath.sv =====
// Datapath of the bandpass unit: section state, shared multiplier, output register
module crb_datapath import crb_pkg::*; #(
  parameter int MAX_STAGES  = MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crb_cmd_t                      cmd_i,
  input  logic [SW-1:0]                 idx_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [COEF_W-1:0]             c_hp_i,
  input  logic [COEF_W-1:0]             c_lp_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o
);

  localparam int PROD_W = COEF_W + ACC_W + 1;

  logic signed [ACC_W-1:0] hp_now_q [MAX_STAGES];
  logic signed [ACC_W-1:0] lp_now_q [MAX_STAGES];
  logic signed [SAMPLE_BITS-1:0] last_q;

  // s0/s1 carry the previous section's old and new outputs along the cascade
  logic signed [ACC_W-1:0]  s0_q, s1_q, diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  logic signed [ACC_W-1:0]  hp_sel, lp_sel, hp_sum, diff_d, scaled, lp_sum;
  logic signed [COEF_W:0]   coef;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  sample_ext, last_ext;
  logic [ACC_W-SAMPLE_BITS:0] out_top;

  assign hp_sel = hp_now_q[idx_i];
  assign lp_sel = lp_now_q[idx_i];

  assign sample_ext = {{(ACC_W-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign last_ext   = {{(ACC_W-SAMPLE_BITS){last_q[SAMPLE_BITS-1]}}, last_q};

  always_comb begin
    hp_sum = crb_sat(crb_ext(hp_sel) + crb_ext(s1_q));
    if (cmd_i.lp) begin
      diff_d = crb_sat(crb_ext(s1_q) - crb_ext(lp_sel));
    end else begin
      diff_d = crb_sat(crb_ext(hp_sum) - crb_ext(s0_q));
    end
  end

  assign coef    = $signed({1'b0, (cmd_i.lp ? c_lp_i : c_hp_i)});
  // arithmetic shift floors toward minus infinity
  assign prod_sh = prod_q >>> COEF_SHIFT;
  assign scaled  = crb_sat(prod_sh[ACC_W+1:0]);
  assign lp_sum  = crb_sat(crb_ext(lp_sel) + crb_ext(scaled));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        hp_now_q[i] <= '0;
        lp_now_q[i] <= '0;
      end
      last_q <= '0;
    end else begin
      if (cmd_i.load) begin
        last_q <= sample_i;
      end
      if (cmd_i.wb && !cmd_i.lp) begin
        hp_now_q[idx_i] <= scaled;
      end
      if (cmd_i.wb && cmd_i.lp) begin
        lp_now_q[idx_i] <= lp_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s1_q <= sample_ext;
      s0_q <= last_ext;
    end else if (cmd_i.wb) begin
      if (cmd_i.lp) begin
        s1_q <= lp_sum;
      end else begin
        s0_q <= hp_sel;
        s1_q <= scaled;
      end
    end
    if (cmd_i.pre) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mul) begin
      prod_q <= coef * diff_q;
    end
    if (cmd_i.cap) begin
      out_q <= (&out_top || !(|out_top)) ? s1_q[SAMPLE_BITS-1:0] :
               (s1_q[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                                {1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end
  end

  assign out_top    = s1_q[ACC_W-1:SAMPLE_BITS-1];
  assign filtered_o = out_q;

endmodule

// ===== rtl/core/crb_ctrl.sv =====
// Controller of the bandpass unit: walks the sections and runs the handshakes
module crb_ctrl import crb_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic            hp_only_i,
  input  logic [NS_W-1:0] num_stages_i,
  output crb_cmd_t        cmd_o,
  output logic [SW-1:0]   idx_o
);

`include "cascaded_recursive_bandpass_unit_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_HP_PRE, ST_HP_MUL, ST_HP_WB,
    ST_LP_PRE, ST_LP_MUL, ST_LP_WB, ST_FIN
  } state_e;

  state_e        state_q;
  logic [SW-1:0] idx_q;
  logic          out_valid_q;
  logic [SW-1:0] last_idx;
  logic          accept, out_free, is_last;

  // zero stages run as one, too many as the maximum
  always_comb begin
    priority if (num_stages_i == '0) begin
      last_idx = '0;
    end else if (int'(num_stages_i) > MAX_STAGES) begin
      last_idx = SW'(MAX_STAGES - 1);
    end else begin
      last_idx = SW'(num_stages_i - NS_W'(1));
    end
  end

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_last  = (idx_q == last_idx);

  always_comb begin
    cmd_o.load = accept;
    cmd_o.pre  = (state_q == ST_HP_PRE) || (state_q == ST_LP_PRE);
    cmd_o.mul  = (state_q == ST_HP_MUL) || (state_q == ST_LP_MUL);
    cmd_o.wb   = (state_q == ST_HP_WB)  || (state_q == ST_LP_WB);
    cmd_o.lp   = (state_q == ST_LP_PRE) || (state_q == ST_LP_MUL) || (state_q == ST_LP_WB);
    cmd_o.cap  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one taken on this edge
      if (cmd_o.cap) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            state_q <= ST_HP_PRE;
          end
        end
        ST_HP_PRE: state_q <= ST_HP_MUL;
        ST_HP_MUL: state_q <= ST_HP_WB;
        ST_HP_WB: begin
          if (!is_last) begin
            idx_q   <= idx_q + SW'(1);
            state_q <= ST_HP_PRE;
          end else if (hp_only_i) begin
            state_q <= ST_FIN;
          end else begin
            idx_q   <= '0;
            state_q <= ST_LP_PRE;
          end
        end
        ST_LP_PRE: state_q <= ST_LP_MUL;
        ST_LP_MUL: state_q <= ST_LP_WB;
        ST_LP_WB: begin
          if (!is_last) begin
            idx_q   <= idx_q + SW'(1);
            state_q <= ST_LP_PRE;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign idx_o       = idx_q;

  `CRB_ASSERT_NXT(a_accept_starts, accept, state_q == ST_HP_PRE, "accepted word did not start the cascade")
  `CRB_ASSERT_IMP(a_valid_from_fin, $rose(out_valid_q), $past(state_q == ST_FIN), "result raised outside the final step")
  `CRB_ASSERT_NXT(a_fin_holds, (state_q == ST_FIN) && out_valid_q && !out_ready_i, state_q == ST_FIN, "result overwritten while stalled")
  `CRB_ASSERT_IMP(a_idx_range, state_q != ST_IDLE, idx_q <= last_idx, "section index beyond the active count")

endmodule

// ===== tb/crb_bandpass_checker.sv =====
// Bandpass unit checker: watches both channels and the register port, predicts and compares
module crb_bandpass_checker import crb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  crb_sample_if                in_w,
  crb_filtered_if              out_w,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   checked_o
);

  localparam int SMP_W  = SAMPLE_BITS_DEF;
  localparam int MAX_ST = MAX_STAGES_DEF;

  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint SMP_HI = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint SMP_LO = -SMP_HI - 1;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [SMP_W-1:0] smp_t;

  // shadow of the filter registers
  logic [COEF_W-1:0] hp_coef;
  logic [COEF_W-1:0] lp_coef;
  logic              hp_only;
  logic [NS_W-1:0]   stage_cnt;

  // shadow of the section state
  acc_t hp_cur  [MAX_ST];
  acc_t hp_prev [MAX_ST];
  acc_t lp_cur  [MAX_ST];
  smp_t prev_sample;

  smp_t filtered_q [$];
  int   fail_cnt;
  int   match_cnt;

  function automatic acc_t clip_acc(input longint v);
    if (v > ACC_HI) return acc_t'(ACC_HI);
    if (v < ACC_LO) return acc_t'(ACC_LO);
    return acc_t'(v);
  endfunction

  // coefficient product, floored by the arithmetic shift
  function automatic acc_t coef_mul(input logic [COEF_W-1:0] c, input acc_t v);
    longint p;
    p = longint'(c) * longint'(v);
    return clip_acc(p >>> COEF_SHIFT);
  endfunction

  function automatic smp_t filter_sample(input smp_t smp);
    int     active;
    int     n;
    longint s0;
    longint s1;
    longint y;
    active = (stage_cnt == 0) ? 1 : ((stage_cnt > MAX_ST) ? MAX_ST : int'(stage_cnt));
    for (n = 0; n < active; n++) begin
      if (n == 0) begin
        s0 = longint'(prev_sample);
        s1 = longint'(smp);
      end else begin
        s0 = longint'(hp_prev[n-1]);
        s1 = longint'(hp_cur[n-1]);
      end
      hp_prev[n] = hp_cur[n];
      hp_cur[n]  = coef_mul(hp_coef,
                            clip_acc(longint'(clip_acc(longint'(hp_cur[n]) + s1)) - s0));
    end
    if (hp_only) begin
      y = longint'(hp_cur[active-1]);
    end else begin
      for (n = 0; n < active; n++) begin
        s0 = (n == 0) ? longint'(hp_cur[active-1]) : longint'(lp_cur[n-1]);
        lp_cur[n] = clip_acc(longint'(lp_cur[n]) +
                             longint'(coef_mul(lp_coef, clip_acc(s0 - longint'(lp_cur[n])))));
      end
      y = longint'(lp_cur[active-1]);
    end
    prev_sample = smp;
    if (y > SMP_HI) y = SMP_HI;
    if (y < SMP_LO) y = SMP_LO;
    return smp_t'(y);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smp_t want;
    if (!rst_ni) begin
      hp_coef     = COEF_ONE;
      lp_coef     = COEF_ONE;
      hp_only     = 1'b0;
      stage_cnt   = NS_W'(1);
      prev_sample = '0;
      for (int n = 0; n < MAX_ST; n++) begin
        hp_cur[n]  = '0;
        hp_prev[n] = '0;
        lp_cur[n]  = '0;
      end
      filtered_q.delete();
      fail_cnt     = 0;
      match_cnt    = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (crb_cfg_idx_e'(cfg_idx_i))
          CFG_C_HP:       hp_coef   = cfg_data_i[COEF_W-1:0];
          CFG_C_LP:       lp_coef   = cfg_data_i[COEF_W-1:0];
          CFG_HP_ONLY:    hp_only   = cfg_data_i[0];
          CFG_NUM_STAGES: stage_cnt = cfg_data_i[NS_W-1:0];
          default: ;
        endcase
      end
      // outgoing word first: it always belongs to an older sample
      if (out_w.valid && out_w.ready) begin
        if (filtered_q.size() == 0) begin
          $error("filtered: expected no word, got %0d", out_w.filtered);
          fail_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (out_w.filtered !== want) begin
            $error("filtered: expected %0d, got %0d", want, out_w.filtered);
            fail_cnt++;
          end
          match_cnt++;
        end
      end
      if (in_w.valid && in_w.ready) begin
        filtered_q.push_back(filter_sample(in_w.sample));
      end
      mismatches_o <= fail_cnt;
      pending_o    <= filtered_q.size();
      checked_o    <= match_cnt;
    end
  end

endmodule

// ===== tb/cascaded_recursive_bandpass_unit_test.sv =====
// Testbench top of the bandpass unit: clock, reset, stimulus and verdict
module cascaded_recursive_bandpass_unit_test;
  import crb_pkg::*;

  localparam int          SMP_W       = SAMPLE_BITS_DEF;
  localparam int          SETTLE      = 60;        // above the 8-section bandpass latency
  localparam int          PHASES      = 12;
  localparam int          PHASE_WORDS = 163;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef logic signed [SMP_W-1:0] sample_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we;
  crb_cfg_idx_e cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int checked;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt = 0;
  int          sent_cnt;
  int          settings_cnt;

  crb_sample_if   #(.SAMPLE_BITS(SMP_W)) smp_w ();
  crb_filtered_if #(.SAMPLE_BITS(SMP_W)) flt_w ();

  cascaded_recursive_bandpass_unit #(
    .MAX_STAGES (MAX_STAGES_DEF),
    .SAMPLE_BITS(SMP_W)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (smp_w),
    .out_o     (flt_w),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  crb_bandpass_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (smp_w),
    .out_w       (flt_w),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    flt_w.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("cascaded_recursive_bandpass_unit_test: done, errors");
      $finish;
    end
  end

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return '0;
      1:       return COEF_ONE;
      2:       return '1;
      3:       return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(131072, 110000));
    endcase
  endfunction

  // mostly short cascades, now and then the clamped counts
  function automatic logic [NS_W-1:0] pick_stages();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NS_W'($urandom_range(15, 9));
      2:       return NS_W'(MAX_STAGES_DEF);
      default: return NS_W'($urandom_range(3, 1));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(3))
      0, 1:    return sample_t'($urandom);
      2:       return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return ($urandom_range(1) != 0) ? sample_t'(24'sh7FFFFF) : sample_t'(24'sh800000);
    endcase
  endfunction

  task automatic push_sample(input sample_t s);
    int unsigned gap;
    gap = 0;
    while (($urandom_range(99) < send_idle_pct) && (gap < 40)) gap++;
    if (gap != 0) begin
      smp_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_w.valid  <= 1'b1;
    smp_w.sample <= s;
    @(posedge clk_i);
    while (!smp_w.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_words(input sample_t words[$]);
    foreach (words[i]) push_sample(words[i]);
    smp_w.valid <= 1'b0;
  endtask

  // checker counts are registered and lag the edge, hence the leading edge
  task automatic wait_drained(input int unsigned settle);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // upper data bits of the narrow registers carry noise, they must be ignored
  task automatic load_settings(input logic [COEF_W-1:0] hp_c, input logic [COEF_W-1:0] lp_c,
                               input logic hp_only, input logic [NS_W-1:0] stages);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_C_HP;
    cfg_data <= hp_c;
    @(posedge clk_i);
    cfg_idx  <= CFG_C_LP;
    cfg_data <= lp_c;
    @(posedge clk_i);
    cfg_idx  <= CFG_HP_ONLY;
    cfg_data <= {(CFG_W-1)'($urandom), hp_only};
    @(posedge clk_i);
    cfg_idx  <= CFG_NUM_STAGES;
    cfg_data <= {(CFG_W-NS_W)'($urandom), stages};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    settings_cnt++;
  endtask

  initial begin
    sample_t top_w;
    sample_t bot_w;
    top_w          = 24'sh7FFFFF;
    bot_w          = 24'sh800000;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_cnt       = 0;
    settings_cnt   = 0;
    smp_w.valid    <= 1'b0;
    smp_w.sample   <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_C_HP;
    cfg_data       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: unity coefficients, one bandpass section
    send_words('{top_w, bot_w, top_w, bot_w, sample_t'(0), sample_t'(-1)});
    // gain near two on both cascades, stage count above the maximum
    wait_drained(SETTLE);
    load_settings('1, '1, 1'b0, NS_W'(15));
    send_words('{top_w, bot_w, top_w, bot_w, top_w, bot_w});
    // zero coefficients, highpass only, stage count zero
    wait_drained(SETTLE);
    load_settings('0, '0, 1'b1, '0);
    send_words('{sample_t'(1), sample_t'(-1), top_w, bot_w});
    wait_drained(SETTLE);
    load_settings(COEF_ONE, '1, 1'b1, NS_W'(MAX_STAGES_DEF));
    send_words('{top_w, bot_w, top_w, bot_w});
    // drop to two sections: the upper ones must hold their state
    wait_drained(SETTLE);
    load_settings(COEF_ONE, COEF_ONE, 1'b0, NS_W'(2));
    send_words('{sample_t'(4096), bot_w, sample_t'(0)});

    for (int p = 0; p < PHASES; p++) begin
      wait_drained(SETTLE);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      load_settings(pick_coef(), pick_coef(), 1'($urandom_range(1)), pick_stages());
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k == PHASE_WORDS / 2) begin
          // hold the input until the unit has emptied
          smp_w.valid <= 1'b0;
          wait_drained(0);
        end
        push_sample(pick_sample());
      end
      smp_w.valid <= 1'b0;
    end

    wait_drained(SETTLE);
    $display("Covered %0d samples under %0d register settings, %0d filtered words compared.",
             sent_cnt, settings_cnt + 1, checked);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("cascaded_recursive_bandpass_unit_test: done, clean");
    end else begin
      $display("cascaded_recursive_bandpass_unit_test: done, errors");
    end
    $finish;
  end

endmodule
